// File: hw/rtl/top_k_sorted_score_table_defines.svh
// Assertion macros used by the score table RTL.
`ifndef TOP_K_SORTED_SCORE_TABLE_DEFINES_SVH
`define TOP_K_SORTED_SCORE_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is active.
`define STK_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define STK_ASSERT_NXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`else

`define STK_ASSERT_IMP(label, clk, rst_n, pre, post, msg)
`define STK_ASSERT_NXT(label, clk, rst_n, pre, post, msg)

`endif

`endif

// File: hw/rtl/stk_pkg.sv
`timescale 1ns / 1ps

package stk_pkg;

  // Action codes of an input transaction
  localparam logic [2:0] ACT_INSERT = 3'd0;
  localparam logic [2:0] ACT_REMOVE = 3'd1;
  localparam logic [2:0] ACT_QUERY  = 3'd2;
  localparam logic [2:0] ACT_READ   = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;

  // Most records one readout returns
  localparam int RESULT_CAP = 16;

  // One stored record
  typedef struct packed {
    logic signed [31:0] score;
    logic [15:0]        level;
    logic [31:0]        survival_time;
    logic [31:0]        stamp;
    logic [7:0]         difficulty;
    logic [15:0]        achievements;
  } rec_t;

  // Per-cycle operation of the cell row
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_e;

  // Broadcast from the controller to every cell
  typedef struct packed {
    cell_op_e op;
    rec_t     rec;
  } cell_ctrl_t;

endpackage

// File: hw/rtl/stk_cell.sv
`timescale 1ns / 1ps

module stk_cell (
  input  logic               clk_i,
  input  stk_pkg::cell_ctrl_t ctrl_i,
  input  logic               valid_i,
  input  logic               wrap_i,
  input  logic               rm_sel_i,
  input  logic               prev_keep_i,
  input  stk_pkg::rec_t      prev_rec_i,
  input  stk_pkg::rec_t      next_rec_i,
  input  stk_pkg::rec_t      head_rec_i,
  output stk_pkg::rec_t      rec_o,
  output logic               keep_o,
  output logic               gt_o
);
  import stk_pkg::*;

  rec_t rec_q;
  rec_t rec_d;

  // Compare the stored score with the broadcast score
  assign keep_o = valid_i && ($signed(rec_q.score) >= $signed(ctrl_i.rec.score));
  assign gt_o   = valid_i && ($signed(rec_q.score) >  $signed(ctrl_i.rec.score));
  assign rec_o  = rec_q;

  // Pick the next record: hold, take the new one, or take a neighbor's
  always_comb begin
    rec_d = rec_q;
    unique case (ctrl_i.op)
      CELL_HOLD: begin
      end
      CELL_INSERT: begin
        if (!keep_o) begin
          if (prev_keep_i) begin
            rec_d = ctrl_i.rec;
          end else begin
            rec_d = prev_rec_i;
          end
        end
      end
      CELL_REMOVE: begin
        if (rm_sel_i) begin
          rec_d = next_rec_i;
        end
      end
      CELL_ROTATE: begin
        rec_d = wrap_i ? head_rec_i : next_rec_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

endmodule

// File: hw/rtl/top_k_sorted_score_table.sv
// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid_i / in_stall_o   | action, score, record fields, index, count
// out     | output    | out_valid_o / out_stall_i | rank, new_best, entry_valid, record, last
//
// Insert and remove shift the cell row; rank query and clear move no records.
// A readout rotates the occupied ring once, one cell per cycle, pausing while
// an emitted record waits on a stalled output.
// Reset empties the table at once (occupancy goes to zero); records need no clearing.
// The input stalls during a readout and while a result waits in the output register.
`timescale 1ns / 1ps
`include "top_k_sorted_score_table_defines.svh"

module top_k_sorted_score_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         action_i,
  input  logic signed [31:0] score_i,
  input  logic [15:0]        level_i,
  input  logic [31:0]        survival_time_i,
  input  logic [31:0]        stamp_i,
  input  logic [7:0]         difficulty_i,
  input  logic [15:0]        achievements_i,
  input  logic [3:0]         index_i,
  input  logic [4:0]         count_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [4:0]         rank_o,
  output logic               new_best_o,
  output logic               entry_valid_o,
  output logic signed [31:0] out_score_o,
  output logic [15:0]        out_level_o,
  output logic [31:0]        out_survival_time_o,
  output logic [31:0]        out_stamp_o,
  output logic [7:0]         out_difficulty_o,
  output logic [15:0]        out_achievements_o,
  output logic               last_o
);
  import stk_pkg::*;

  localparam int OCC_W  = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W  = (OCC_W > 5) ? OCC_W : 5;
  localparam int SUM_W  = ($clog2(TABLE_DEPTH + 2) > 5) ? $clog2(TABLE_DEPTH + 2) : 5;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  // Control state
  logic             state_q, state_d;
  logic [OCC_W-1:0] occ_q, occ_d;
  logic [OCC_W-1:0] step_q, step_d;
  logic [4:0]       num_q, num_d;
  logic             out_valid_q, out_valid_d;

  // Output payload
  logic [4:0] rank_q, rank_d;
  logic       new_best_q, new_best_d;
  logic       entry_valid_q, entry_valid_d;
  rec_t       out_rec_q, out_rec_d;
  logic       last_q, last_d;

  // Cell row
  cell_ctrl_t             ctrl;
  rec_t                   cell_rec  [TABLE_DEPTH];
  rec_t                   prev_rec  [TABLE_DEPTH];
  rec_t                   next_rec  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] keep_v, gt_v, valid_v, wrap_v, rm_sel_v, prev_keep_v, bnd_v;

  logic             in_acc;
  logic             out_free;
  logic [SUM_W-1:0] gt_cnt;
  logic [SUM_W-1:0] rank_sum;
  logic [CMP_W-1:0] read_lim;
  logic [CMP_W-1:0] read_n;
  logic             emit;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q == ST_READ) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Build the cell row and its neighbor links
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign prev_keep_v[g] = 1'b1;
      assign prev_rec[g]    = ctrl.rec;
    end else begin : g_inner
      assign prev_keep_v[g] = keep_v[g-1];
      assign prev_rec[g]    = cell_rec[g-1];
    end
    if (g == TABLE_DEPTH - 1) begin : g_end
      assign next_rec[g] = cell_rec[g];
      assign bnd_v[g]    = gt_v[g];
    end else begin : g_mid
      assign next_rec[g] = cell_rec[g+1];
      assign bnd_v[g]    = gt_v[g] && !gt_v[g+1];
    end
    assign valid_v[g]  = OCC_W'(g) < occ_q;
    assign wrap_v[g]   = OCC_W'(g + 1) == occ_q;
    assign rm_sel_v[g] = CMP_W'(g) >= CMP_W'(index_i);

    stk_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .valid_i     (valid_v[g]),
      .wrap_i      (wrap_v[g]),
      .rm_sel_i    (rm_sel_v[g]),
      .prev_keep_i (prev_keep_v[g]),
      .prev_rec_i  (prev_rec[g]),
      .next_rec_i  (next_rec[g]),
      .head_rec_i  (cell_rec[0]),
      .rec_o       (cell_rec[g]),
      .keep_o      (keep_v[g]),
      .gt_o        (gt_v[g])
    );
  end

  // Encode the last cell with a greater score; scores are sorted, so one boundary
  always_comb begin
    gt_cnt = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (bnd_v[i]) begin
        gt_cnt = gt_cnt | SUM_W'(i + 1);
      end
    end
  end
  assign rank_sum = gt_cnt + SUM_W'(1);

  // Clip the readout length to occupancy and to the result cap
  always_comb begin
    read_lim = (CMP_W'(count_i) < CMP_W'(occ_q)) ? CMP_W'(count_i) : CMP_W'(occ_q);
    read_n   = (read_lim > CMP_W'(RESULT_CAP)) ? CMP_W'(RESULT_CAP) : read_lim;
  end

  assign emit = CMP_W'(step_q) < CMP_W'(num_q);

  // Decode the transaction and sequence the readout
  always_comb begin
    state_d       = state_q;
    occ_d         = occ_q;
    step_d        = step_q;
    num_d         = num_q;
    out_valid_d   = out_valid_q && out_stall_i;
    rank_d        = rank_q;
    new_best_d    = new_best_q;
    entry_valid_d = entry_valid_q;
    out_rec_d     = out_rec_q;
    last_d        = last_q;
    ctrl.op       = CELL_HOLD;
    ctrl.rec      = '{score: score_i, level: level_i, survival_time: survival_time_i,
                      stamp: stamp_i, difficulty: difficulty_i,
                      achievements: achievements_i};
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (action_i)
            ACT_INSERT: begin
              ctrl.op = CELL_INSERT;
              if (occ_q < OCC_W'(TABLE_DEPTH)) begin
                occ_d = occ_q + OCC_W'(1);
              end
            end
            ACT_REMOVE: begin
              if (CMP_W'(index_i) < CMP_W'(occ_q)) begin
                ctrl.op = CELL_REMOVE;
                occ_d   = occ_q - OCC_W'(1);
              end
            end
            ACT_QUERY: begin
              out_valid_d   = 1'b1;
              rank_d        = rank_sum[4:0];
              new_best_d    = !keep_v[0];
              entry_valid_d = 1'b0;
              out_rec_d     = '0;
              last_d        = 1'b1;
            end
            ACT_READ: begin
              if (read_n != '0) begin
                state_d = ST_READ;
                num_d   = read_n[4:0];
                step_d  = '0;
              end
            end
            ACT_CLEAR: begin
              occ_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        // Advance the ring; while emitting, wait for a free output slot
        if (!emit || out_free) begin
          ctrl.op = CELL_ROTATE;
          if (emit) begin
            out_valid_d   = 1'b1;
            rank_d        = '0;
            new_best_d    = 1'b0;
            entry_valid_d = 1'b1;
            out_rec_d     = cell_rec[0];
            last_d        = (CMP_W'(step_q) + CMP_W'(1)) == CMP_W'(num_q);
          end
          step_d = step_q + OCC_W'(1);
          if (step_d == occ_q) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      occ_q       <= '0;
      step_q      <= '0;
      num_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      step_q      <= step_d;
      num_q       <= num_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rank_q        <= rank_d;
    new_best_q    <= new_best_d;
    entry_valid_q <= entry_valid_d;
    out_rec_q     <= out_rec_d;
    last_q        <= last_d;
  end

  assign out_valid_o         = out_valid_q;
  assign rank_o              = rank_q;
  assign new_best_o          = new_best_q;
  assign entry_valid_o       = entry_valid_q;
  assign out_score_o         = out_rec_q.score;
  assign out_level_o         = out_rec_q.level;
  assign out_survival_time_o = out_rec_q.survival_time;
  assign out_stamp_o         = out_rec_q.stamp;
  assign out_difficulty_o    = out_rec_q.difficulty;
  assign out_achievements_o  = out_rec_q.achievements;
  assign last_o              = last_q;

  // Checks
  `STK_ASSERT_IMP(a_occ_bound, clk_i, rst_ni, 1'b1,
                  occ_q <= OCC_W'(TABLE_DEPTH), "occupancy above depth")
  `STK_ASSERT_IMP(a_read_stall, clk_i, rst_ni, state_q == ST_READ,
                  in_stall_o && (step_q < occ_q), "readout not holding input or step past ring")
  `STK_ASSERT_NXT(a_clear, clk_i, rst_ni, in_acc && (action_i == ACT_CLEAR),
                  occ_q == '0, "clear left records")
  `STK_ASSERT_IMP(a_query_last, clk_i, rst_ni, out_valid_o && !entry_valid_o,
                  last_o, "rank result without last")
  for (genvar g = 0; g < TABLE_DEPTH - 1; g++) begin : g_sort
    `STK_ASSERT_IMP(a_sorted, clk_i, rst_ni, (state_q == ST_IDLE) && valid_v[g+1],
                    $signed(cell_rec[g].score) >= $signed(cell_rec[g+1].score),
                    "table out of order")
  end

endmodule

// File: test/tb_top_k_sorted_score_table.sv
`timescale 1ns / 1ps

module tb_top_k_sorted_score_table;
  import stk_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int RANDOM_ITEMS = 160;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 8;
  localparam int REPORT_LIMIT = 10;

  // Action codes the block ignores
  localparam logic [2:0] ACT_SPARE_LO = ACT_CLEAR + 3'd1;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  localparam logic signed [31:0] SCORE_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] SCORE_MIN = 32'sh80000000;

  // One result transaction as seen on the output channel
  typedef struct packed {
    logic [4:0] rank;
    logic       new_best;
    logic       entry_valid;
    rec_t       rec;
    logic       last;
  } table_result_t;

  // Mirror of the sorted table; queues the results each accepted transaction causes
  class score_table_tracker;
    rec_t          rows[TABLE_DEPTH];
    int unsigned   fill;
    table_result_t pending_results[$];
    int unsigned   mismatches;

    function new();
      fill = 0;
      mismatches = 0;
    endfunction

    function void note_transaction(logic [2:0] action, rec_t rec, logic [3:0] index,
                                   logic [4:0] count);
      int unsigned   pos;
      int unsigned   i;
      int unsigned   n;
      int unsigned   rank;
      table_result_t res;
      case (action)
        ACT_INSERT: begin
          // Place after every record scoring greater or equal
          pos = 0;
          while (pos < fill && $signed(rows[pos].score) >= $signed(rec.score)) pos++;
          if (pos < TABLE_DEPTH) begin
            i = (fill < TABLE_DEPTH) ? fill : TABLE_DEPTH - 1;
            while (i > pos) begin
              rows[i] = rows[i - 1];
              i--;
            end
            rows[pos] = rec;
            if (fill < TABLE_DEPTH) fill++;
          end
        end
        ACT_REMOVE: begin
          if (32'(index) < fill) begin
            for (i = 32'(index); i + 1 < fill; i++) rows[i] = rows[i + 1];
            fill--;
          end
        end
        ACT_QUERY: begin
          rank = 1;
          for (i = 0; i < fill; i++)
            if ($signed(rows[i].score) > $signed(rec.score)) rank++;
          res = '0;
          res.rank = rank[4:0];
          res.new_best = (fill == 0) || ($signed(rec.score) > $signed(rows[0].score));
          res.last = 1'b1;
          pending_results = {pending_results, res};
        end
        ACT_READ: begin
          // Cut the readout at occupancy and at the result cap
          n = 32'(count);
          if (n > fill) n = fill;
          if (n > RESULT_CAP) n = RESULT_CAP;
          for (i = 0; i < n; i++) begin
            res = '0;
            res.entry_valid = 1'b1;
            res.rec = rows[i];
            res.last = (i + 1 == n);
            pending_results = {pending_results, res};
          end
        end
        ACT_CLEAR: fill = 0;
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: mismatch on %s: expected %h, got %h", $time, name, want, got);
      end
    endfunction

    function void check_result(table_result_t got);
      table_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result with none expected: score %h, last %b", $time,
                   got.rec.score, got.last);
        return;
      end
      want = pending_results.pop_front();
      compare_field("rank", 32'(want.rank), 32'(got.rank));
      compare_field("new_best", 32'(want.new_best), 32'(got.new_best));
      compare_field("entry_valid", 32'(want.entry_valid), 32'(got.entry_valid));
      compare_field("out_score", want.rec.score, got.rec.score);
      compare_field("out_level", 32'(want.rec.level), 32'(got.rec.level));
      compare_field("out_survival_time", want.rec.survival_time,
                    got.rec.survival_time);
      compare_field("out_stamp", want.rec.stamp, got.rec.stamp);
      compare_field("out_difficulty", 32'(want.rec.difficulty),
                    32'(got.rec.difficulty));
      compare_field("out_achievements", 32'(want.rec.achievements),
                    32'(got.rec.achievements));
      compare_field("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [2:0]         action_i;
  logic signed [31:0] score_i;
  logic [15:0]        level_i;
  logic [31:0]        survival_time_i;
  logic [31:0]        stamp_i;
  logic [7:0]         difficulty_i;
  logic [15:0]        achievements_i;
  logic [3:0]         index_i;
  logic [4:0]         count_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [4:0]         rank_o;
  logic               new_best_o;
  logic               entry_valid_o;
  logic signed [31:0] out_score_o;
  logic [15:0]        out_level_o;
  logic [31:0]        out_survival_time_o;
  logic [31:0]        out_stamp_o;
  logic [7:0]         out_difficulty_o;
  logic [15:0]        out_achievements_o;
  logic               last_o;

  score_table_tracker tracker = new();
  table_result_t      seen;
  bit                 in_quiet;
  bit                 out_quiet;
  int                 sent;

  top_k_sorted_score_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .action_i,
    .score_i,
    .level_i,
    .survival_time_i,
    .stamp_i,
    .difficulty_i,
    .achievements_i,
    .index_i,
    .count_i,
    .out_valid_o,
    .out_stall_i,
    .rank_o,
    .new_best_o,
    .entry_valid_o,
    .out_score_o,
    .out_level_o,
    .out_survival_time_o,
    .out_stamp_o,
    .out_difficulty_o,
    .out_achievements_o,
    .last_o
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(0, 1);
    if (roll < 92) return $urandom_range(2, 5);
    return $urandom_range(10, 30);
  endfunction

  // Favor a narrow band of scores so ties happen often
  function automatic logic signed [31:0] random_score();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return int'($urandom_range(0, 8)) - 4;
    if (roll == 4) return $urandom_range(0, 1) ? SCORE_MAX : SCORE_MIN;
    return $urandom;
  endfunction

  function automatic rec_t random_rec();
    rec_t r;
    r.score = random_score();
    r.level = 16'($urandom);
    r.survival_time = $urandom;
    r.stamp = $urandom;
    r.difficulty = 8'($urandom);
    r.achievements = 16'($urandom);
    return r;
  endfunction

  function automatic rec_t scored(rec_t base, logic signed [31:0] s);
    base.score = s;
    return base;
  endfunction

  // Drive one input transaction and hold it until accepted
  task automatic send_item(input logic [2:0] action, input rec_t rec,
                           input logic [3:0] index, input logic [4:0] count);
    int gap;
    gap = in_quiet ? 0 : gap_len();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    action_i = action;
    score_i = rec.score;
    level_i = rec.level;
    survival_time_i = rec.survival_time;
    stamp_i = rec.stamp;
    difficulty_i = rec.difficulty;
    achievements_i = rec.achievements;
    index_i = index;
    count_i = count;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_transaction(action, rec, index, count);
    if (action <= ACT_CLEAR) sent++;
    @(negedge clk_i);
  endtask

  // Pick one operation with inserts and queries weighted up
  task automatic random_op();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40)
      send_item(ACT_INSERT, random_rec(), 4'($urandom), 5'($urandom));
    else if (roll < 55)
      send_item(ACT_REMOVE, random_rec(), 4'($urandom_range(0, 15)), 5'($urandom));
    else if (roll < 75)
      send_item(ACT_QUERY, random_rec(), 4'($urandom), 5'($urandom));
    else if (roll < 90)
      send_item(ACT_READ, random_rec(), 4'($urandom), 5'($urandom_range(0, 16)));
    else if (roll < 93)
      send_item(ACT_CLEAR, random_rec(), 4'($urandom), 5'($urandom));
    else
      send_item(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)), random_rec(),
                4'($urandom), 5'($urandom));
  endtask

  // Randomly stall the output channel
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
      end else if (out_quiet) begin
        out_stall_i = 1'b0;
      end else begin
        out_stall_i = !out_stall_i;
        stall_left = gap_len();
      end
    end
  end

  // Check every accepted result transaction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.rank = rank_o;
      seen.new_best = new_best_o;
      seen.entry_valid = entry_valid_o;
      seen.rec.score = out_score_o;
      seen.rec.level = out_level_o;
      seen.rec.survival_time = out_survival_time_o;
      seen.rec.stamp = out_stamp_o;
      seen.rec.difficulty = out_difficulty_o;
      seen.rec.achievements = out_achievements_o;
      seen.last = last_o;
      tracker.check_result(seen);
    end
  end

  // Bound the run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("tb_top_k_sorted_score_table NOT OK");
    $finish;
  end

  initial begin
    int n;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    action_i = ACT_INSERT;
    score_i = '0;
    level_i = '0;
    survival_time_i = '0;
    stamp_i = '0;
    difficulty_i = '0;
    achievements_i = '0;
    index_i = '0;
    count_i = '0;
    in_quiet = 1'b0;
    out_quiet = 1'b0;
    sent = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty table, extremes, ties, out-of-range remove, spare codes
    send_item(ACT_QUERY, scored('0, 0), 0, 0);
    send_item(ACT_READ, random_rec(), 0, 16);
    send_item(ACT_REMOVE, random_rec(), 0, 0);
    send_item(ACT_INSERT, scored('1, SCORE_MAX), '1, '1);
    send_item(ACT_INSERT, scored('0, SCORE_MIN), '0, '0);
    send_item(ACT_INSERT, scored(random_rec(), 0), 0, 0);
    send_item(ACT_INSERT, scored(random_rec(), 0), 0, 0);
    send_item(ACT_QUERY, scored(random_rec(), 0), 0, 0);
    send_item(ACT_QUERY, scored(random_rec(), SCORE_MAX), 0, 0);
    send_item(ACT_QUERY, scored(random_rec(), SCORE_MIN), 0, 0);
    send_item(ACT_QUERY, scored(random_rec(), 1), 0, 0);
    send_item(ACT_READ, random_rec(), 0, 0);
    send_item(ACT_READ, random_rec(), 0, 2);
    send_item(ACT_READ, random_rec(), 0, 16);
    send_item(ACT_REMOVE, random_rec(), 15, 0);
    send_item(ACT_REMOVE, random_rec(), 1, 0);
    send_item(ACT_SPARE_LO, random_rec(), 0, 16);
    send_item(ACT_SPARE_HI, random_rec(), 0, 16);
    send_item(ACT_READ, random_rec(), 0, 16);
    send_item(ACT_CLEAR, random_rec(), 0, 0);
    send_item(ACT_READ, random_rec(), 0, 16);
    send_item(ACT_QUERY, scored(random_rec(), -1), 0, 0);

    // Random phases, each with its own idling mood
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      in_quiet = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: begin
          // Insert a random run, sometimes past capacity, then read the table back
          n = $urandom_range(4, 20);
          repeat (n) send_item(ACT_INSERT, random_rec(), 4'($urandom), 5'($urandom));
          send_item(ACT_READ, random_rec(), 4'($urandom), 5'($urandom_range(1, 16)));
        end
        1: begin
          repeat (10) random_op();
        end
        2: begin
          // Rank queries with random scores, then a readout
          n = $urandom_range(3, 8);
          repeat (n) send_item(ACT_QUERY, random_rec(), 4'($urandom), 5'($urandom));
          send_item(ACT_READ, random_rec(), 4'($urandom), 5'($urandom_range(0, 16)));
        end
        default: begin
          // Remove a few, read back, sometimes clear
          n = $urandom_range(1, 5);
          repeat (n) send_item(ACT_REMOVE, random_rec(), 4'($urandom_range(0, 15)),
                               5'($urandom));
          send_item(ACT_READ, random_rec(), 4'($urandom), 16);
          if ($urandom_range(0, 4) == 0)
            send_item(ACT_CLEAR, random_rec(), 4'($urandom), 5'($urandom));
        end
      endcase
    end

    // Drain outstanding results, then let any readout finish
    in_valid_i = 1'b0;
    out_quiet = 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0)
      $display("tb_top_k_sorted_score_table OK");
    else
      $display("tb_top_k_sorted_score_table NOT OK");
    $finish;
  end

endmodule
